@@ rtl/isap_a128_aead_engine_top_assert.svh @@
// assertion macros shared by the engine rtl
`ifndef ISAP_A128_AEAD_ENGINE_TOP_ASSERT_SVH
`define ISAP_A128_AEAD_ENGINE_TOP_ASSERT_SVH

// checked only outside reset
`define ISAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ISAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/isap_pkg.sv @@
`timescale 1ns / 1ps
package isap_pkg;

  typedef logic [4:0][63:0] state_t;

  localparam logic [63:0] IV_KE    = 64'h038040010C0C0C0C;
  localparam logic [63:0] IV_KA    = 64'h028040010C0C0C0C;
  localparam logic [63:0] IV_A     = 64'h018040010C0C0C0C;
  localparam logic [63:0] PAD_FULL = 64'h8000000000000000;
  localparam logic [3:0]  MAX_ROUNDS = 4'd12;
  localparam logic [3:0]  LAST_ROUND = 4'd11;

  localparam logic [1:0] KIND_NONCE = 2'd0;
  localparam logic [1:0] KIND_AD    = 2'd1;
  localparam logic [1:0] KIND_MSG   = 2'd2;
  localparam logic [1:0] KIND_TAG   = 2'd3;

  localparam logic [1:0] OUT_BLOCK   = 2'd0;
  localparam logic [1:0] OUT_TAG     = 2'd1;
  localparam logic [1:0] OUT_VERDICT = 2'd2;

  localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
  localparam logic [1:0] REG_KEY_LOW   = 2'd1;
  localparam logic [1:0] REG_DIRECTION = 2'd2;
  localparam logic [1:0] REG_ROUNDS    = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT, PH_NONCE1, PH_AD, PH_MSG, PH_TAG0, PH_TAG1
  } phase_e;

  typedef enum logic [1:0] {
    SEL_STREAM, SEL_MAC, SEL_SCR
  } sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PERM, S_RK_START, S_RK_BIT, S_RK_DONE, S_AD_ABS, S_ABS_LAST,
    S_ABS_PAD, S_ABS_END, S_MSG_START, S_MSG_OUT, S_MSG_ABS, S_TAG0_OUT,
    S_TAG1_OUT, S_VERD
  } fsm_e;

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] lead_mask(logic [3:0] c);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < c) m[63 - 8*i -: 8] = 8'hFF;
    end
    return m;
  endfunction

  // 10* padding byte right after the c leading bytes, c below eight
  function automatic logic [63:0] pad_bits(logic [3:0] c);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) == c) p[63 - 8*i] = 1'b1;
    end
    return p;
  endfunction

endpackage

@@ rtl/isap_a128_aead_engine_top.sv @@
`timescale 1ns / 1ps
// one ascon round per cycle on a single shared round unit; each permutation runs min(round_count, 12) rounds
// second nonce word: bitwise re-key plus mac init
// data block: longest when a message piece closes open ad
// last message piece: also runs the mac re-key and, when encrypting (direction 0), both tag words
// the input is not ready while an item is in work; results leave through an output register
// reset (rst_ni low, async) clears control, phase, key and direction, round_count to 12
module isap_a128_aead_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // word[63:0], byte_count[67:64], zero[71:68]
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // out_word[63:0], out_bytes[67:64], tag_ok[68], zero
  output logic [1:0]  m_axis_tuser_o,  // out_kind[1:0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import isap_pkg::*;

  fsm_e   state_q, state_d, ret_q, ret_d;
  phase_e phase_q;
  sel_e   sel_q;

  state_t stream_q, mac_q, scr_q, round_in, round_out;
  logic [63:0] n0_q, n1_q, key_hi_q, key_lo_q;
  logic        dir_q, mism_q, rk_ka_q;
  logic [3:0]  rc_q, nr, rnd_q;
  logic [7:0]  bit_cnt_q;

  logic [1:0]  kind_q;
  logic [63:0] w_q, ct_q, ab_val_q, ab_m;
  logic [3:0]  c_q, ab_cnt_q, in_c;
  logic        fin_q, in_fin;

  logic        m_valid_q, m_last_q, m_ok_q;
  logic [1:0]  m_kind_q;
  logic [63:0] m_word_q;
  logic [3:0]  m_bytes_q;

  logic        acc, out_free, rk_bit;
  logic [127:0] rk_src;
  logic [63:0] msg_res, msg_mask;

  assign nr       = (rc_q > MAX_ROUNDS) ? MAX_ROUNDS : rc_q;
  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign in_c     = (s_axis_tdata_i[67:64] > 4'd8) ? 4'd8 : s_axis_tdata_i[67:64];
  assign in_fin   = s_axis_tlast_i || (in_c < 4'd8);
  assign rk_src   = rk_ka_q ? {mac_q[0], mac_q[1]} : {n0_q, n1_q};
  assign rk_bit   = rk_src[7'd127 - bit_cnt_q[6:0]];
  assign msg_mask = lead_mask(c_q);
  assign msg_res  = (w_q ^ stream_q[0]) & msg_mask;
  assign ab_m     = (ab_cnt_q >= 4'd8) ? ab_val_q
                  : ((ab_val_q & lead_mask(ab_cnt_q)) | pad_bits(ab_cnt_q));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, m_ok_q, m_bytes_q, m_word_q};
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

  function automatic fsm_e via_perm(fsm_e r, logic [3:0] n);
    return (n == 4'd0) ? r : S_PERM;
  endfunction

  always_comb begin
    case (sel_q)
      SEL_STREAM: round_in = stream_q;
      SEL_MAC:    round_in = mac_q;
      default:    round_in = scr_q;
    endcase
  end

  isap_round u_round (
    .s_i   (round_in),
    .rnd_i (rnd_q),
    .s_o   (round_out)
  );

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (s_axis_tuser_i)
            KIND_NONCE: if (phase_q == PH_NONCE1) state_d = S_RK_START;
            KIND_AD: begin
              if (phase_q == PH_AD) state_d = in_fin ? S_ABS_LAST : S_AD_ABS;
            end
            KIND_MSG: begin
              if (phase_q == PH_AD) state_d = S_ABS_LAST;
              else if (phase_q == PH_MSG) state_d = S_MSG_START;
            end
            default: if (phase_q == PH_TAG1) state_d = S_VERD;
          endcase
        end
      end
      S_PERM: if (rnd_q == LAST_ROUND) state_d = ret_q;
      S_RK_START: begin
        state_d = via_perm(S_RK_BIT, nr);
        ret_d   = S_RK_BIT;
      end
      S_RK_BIT: begin
        if (bit_cnt_q[7]) state_d = S_RK_DONE;
        else begin
          state_d = via_perm(S_RK_BIT, nr);
          ret_d   = S_RK_BIT;
        end
      end
      S_RK_DONE: begin
        if (rk_ka_q && !dir_q) begin
          state_d = via_perm(S_TAG0_OUT, nr);
          ret_d   = S_TAG0_OUT;
        end else begin
          state_d = via_perm(S_IDLE, nr);
          ret_d   = S_IDLE;
        end
      end
      S_AD_ABS: begin
        state_d = via_perm(S_IDLE, nr);
        ret_d   = S_IDLE;
      end
      S_ABS_LAST: begin
        if (ab_cnt_q >= 4'd8) begin
          state_d = via_perm(S_ABS_PAD, nr);
          ret_d   = S_ABS_PAD;
        end else begin
          state_d = via_perm(S_ABS_END, nr);
          ret_d   = S_ABS_END;
        end
      end
      S_ABS_PAD: begin
        state_d = via_perm(S_ABS_END, nr);
        ret_d   = S_ABS_END;
      end
      S_ABS_END: begin
        if (phase_q == PH_AD) state_d = (kind_q == KIND_MSG) ? S_MSG_START : S_IDLE;
        else state_d = S_RK_START;
      end
      S_MSG_START: begin
        if (c_q != 4'd0) begin
          state_d = via_perm(S_MSG_OUT, nr);
          ret_d   = S_MSG_OUT;
        end else state_d = S_MSG_ABS;
      end
      S_MSG_OUT: if (out_free) state_d = S_MSG_ABS;
      S_MSG_ABS: begin
        if (fin_q) state_d = S_ABS_LAST;
        else begin
          state_d = via_perm(S_IDLE, nr);
          ret_d   = S_IDLE;
        end
      end
      S_TAG0_OUT: if (out_free) state_d = S_TAG1_OUT;
      S_TAG1_OUT: if (out_free) state_d = S_IDLE;
      S_VERD:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      dir_q    <= 1'b0;
      rc_q     <= MAX_ROUNDS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY_HIGH:  key_hi_q <= cfg_data_i;
        REG_KEY_LOW:   key_lo_q <= cfg_data_i;
        REG_DIRECTION: dir_q    <= cfg_data_i[0];
        REG_ROUNDS:    rc_q     <= cfg_data_i[3:0];
        default:       rc_q     <= rc_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free && (state_q == S_MSG_OUT || state_q == S_TAG0_OUT
                 || state_q == S_TAG1_OUT || state_q == S_VERD)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      case (state_q)
        S_MSG_OUT: begin
          m_kind_q <= OUT_BLOCK; m_word_q <= msg_res; m_bytes_q <= c_q;
          m_ok_q <= 1'b0; m_last_q <= 1'b0;
        end
        S_TAG0_OUT: begin
          m_kind_q <= OUT_TAG; m_word_q <= mac_q[0]; m_bytes_q <= 4'd8;
          m_ok_q <= 1'b0; m_last_q <= 1'b0;
        end
        S_TAG1_OUT: begin
          m_kind_q <= OUT_TAG; m_word_q <= mac_q[1]; m_bytes_q <= 4'd8;
          m_ok_q <= 1'b0; m_last_q <= 1'b1;
        end
        S_VERD: begin
          m_kind_q <= OUT_VERDICT; m_word_q <= '0; m_bytes_q <= 4'd0;
          m_ok_q <= !(mism_q || (w_q != mac_q[1])); m_last_q <= 1'b1;
        end
        default: m_ok_q <= m_ok_q;
      endcase
    end
  end

  // control side of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      mism_q    <= 1'b0;
      rk_ka_q   <= 1'b0;
      bit_cnt_q <= '0;
      rnd_q     <= '0;
      sel_q     <= SEL_STREAM;
    end else begin
      rnd_q <= (state_q == S_PERM) ? rnd_q + 4'd1 : MAX_ROUNDS - nr;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (s_axis_tuser_i)
              KIND_NONCE: begin
                if (phase_q == PH_NONCE1) rk_ka_q <= 1'b0;
                else phase_q <= PH_NONCE1;
              end
              KIND_AD: sel_q <= SEL_MAC;
              KIND_MSG: sel_q <= SEL_MAC;
              default: begin
                if (phase_q == PH_TAG0) begin
                  mism_q  <= (s_axis_tdata_i[63:0] != mac_q[0]);
                  phase_q <= PH_TAG1;
                end
              end
            endcase
          end
        end
        S_RK_START: begin
          sel_q     <= SEL_SCR;
          bit_cnt_q <= '0;
        end
        S_RK_BIT: if (!bit_cnt_q[7]) bit_cnt_q <= bit_cnt_q + 8'd1;
        S_RK_DONE: begin
          sel_q <= SEL_MAC;
          if (!rk_ka_q) begin
            phase_q <= PH_AD;
            mism_q  <= 1'b0;
          end else phase_q <= dir_q ? PH_TAG0 : PH_WAIT;
        end
        S_ABS_END: begin
          if (phase_q == PH_AD) phase_q <= PH_MSG;
          else rk_ka_q <= 1'b1;
        end
        S_MSG_START: sel_q <= SEL_STREAM;
        S_MSG_ABS: sel_q <= SEL_MAC;
        S_VERD: begin
          if (out_free) begin
            mism_q  <= 1'b0;
            phase_q <= PH_WAIT;
          end
        end
        default: sel_q <= sel_q;
      endcase
    end
  end

  // payload side of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q <= '0;
      mac_q    <= '0;
    end else begin
      case (state_q)
        S_PERM: begin
          case (sel_q)
            SEL_STREAM: stream_q <= round_out;
            SEL_MAC:    mac_q    <= round_out;
            default:    scr_q    <= round_out;
          endcase
        end
        S_IDLE: begin
          if (acc) begin
            kind_q <= s_axis_tuser_i;
            w_q    <= s_axis_tdata_i[63:0];
            c_q    <= in_c;
            fin_q  <= in_fin;
            if (s_axis_tuser_i == KIND_NONCE) begin
              if (phase_q == PH_NONCE1) n1_q <= s_axis_tdata_i[63:0];
              else n0_q <= s_axis_tdata_i[63:0];
            end
            if (s_axis_tuser_i == KIND_AD && phase_q == PH_AD) begin
              ab_val_q <= s_axis_tdata_i[63:0];
              ab_cnt_q <= in_c;
            end
            // message while associated data is open: close with an empty padding block
            if (s_axis_tuser_i == KIND_MSG && phase_q == PH_AD) begin
              ab_val_q <= '0;
              ab_cnt_q <= 4'd0;
            end
          end
        end
        S_RK_START: scr_q <= {64'h0, 64'h0, (rk_ka_q ? IV_KA : IV_KE), key_lo_q, key_hi_q};
        S_RK_BIT: if (!bit_cnt_q[7]) scr_q[0][63] <= scr_q[0][63] ^ rk_bit;
        S_RK_DONE: begin
          if (!rk_ka_q) begin
            stream_q <= {n1_q, n0_q, scr_q[2], scr_q[1], scr_q[0]};
            mac_q    <= {64'h0, 64'h0, IV_A, n1_q, n0_q};
          end else begin
            mac_q[0] <= scr_q[0];
            mac_q[1] <= scr_q[1];
          end
        end
        S_AD_ABS:   mac_q[0] <= mac_q[0] ^ w_q;
        S_ABS_LAST: mac_q[0] <= mac_q[0] ^ ab_m;
        S_ABS_PAD:  mac_q[0] <= mac_q[0] ^ PAD_FULL;
        S_ABS_END:  if (phase_q == PH_AD) mac_q[4][0] <= ~mac_q[4][0];
        S_MSG_START: if (c_q == 4'd0) ct_q <= '0;
        S_MSG_OUT: if (out_free) ct_q <= dir_q ? (w_q & msg_mask) : msg_res;
        S_MSG_ABS: begin
          if (fin_q) begin
            ab_val_q <= ct_q;
            ab_cnt_q <= c_q;
          end else mac_q[0] <= mac_q[0] ^ ct_q;
        end
        default: mac_q <= mac_q;
      endcase
    end
  end

  `include "isap_a128_aead_engine_top_assert.svh"

  `ISAP_ASSERT(a_perm_rounds, (state_q == S_PERM) |-> (nr != 4'd0 && rnd_q <= LAST_ROUND), "bad round")
  `ISAP_ASSERT(a_rk_count, (!bit_cnt_q[7] || bit_cnt_q[6:0] == 7'd0), "re-key bit counter past 128")
  `ISAP_ASSERT(a_tag_phase, (state_q == S_TAG0_OUT || state_q == S_TAG1_OUT) |-> (phase_q == PH_WAIT), "tag in open session")
  `ISAP_ASSERT_ALWAYS(a_busy_not_ready, (state_q != S_IDLE) |-> !s_axis_tready_o, "ready while busy")
  `ISAP_ASSERT(a_tag_follows, (state_q == S_TAG0_OUT && out_free) |=> (state_q == S_TAG1_OUT), "tag1 not next")

endmodule

@@ rtl/isap_round.sv @@
`timescale 1ns / 1ps
module isap_round (
  input  isap_pkg::state_t s_i,
  input  logic [3:0]       rnd_i,
  output isap_pkg::state_t s_o
);
  import isap_pkg::*;

  logic [63:0] x0, x1, x2, x3, x4;
  logic [63:0] a0, a1, a2, a3, a4;
  logic [63:0] b0, b1, b2, b3, b4;

  always_comb begin
    x0 = s_i[0];
    x1 = s_i[1];
    x2 = s_i[2] ^ {56'h0, 4'(4'd15 - rnd_i), rnd_i};
    x3 = s_i[3];
    x4 = s_i[4];
    // substitution layer
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    a0 = x0 ^ (~x1 & x2);
    a1 = x1 ^ (~x2 & x3);
    a2 = x2 ^ (~x3 & x4);
    a3 = x3 ^ (~x4 & x0);
    a4 = x4 ^ (~x0 & x1);
    b1 = a1 ^ a0;
    b0 = a0 ^ a4;
    b3 = a3 ^ a2;
    b2 = ~a2;
    b4 = a4;
    // linear layer
    s_o[0] = b0 ^ ror64(b0, 19) ^ ror64(b0, 28);
    s_o[1] = b1 ^ ror64(b1, 61) ^ ror64(b1, 39);
    s_o[2] = b2 ^ ror64(b2, 1) ^ ror64(b2, 6);
    s_o[3] = b3 ^ ror64(b3, 10) ^ ror64(b3, 17);
    s_o[4] = b4 ^ ror64(b4, 7) ^ ror64(b4, 41);
  end

endmodule
